FILE: design/soft_repetition_combine_normalize_defines.svh
// Assertion macros for the soft repetition combining block.
`ifndef SOFT_REPETITION_COMBINE_NORMALIZE_DEFINES_SVH
`define SOFT_REPETITION_COMBINE_NORMALIZE_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define SRCN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SRCN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SRCN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`define SRCN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: design/srcn_pkg.sv
// Shared types and constants for the soft repetition combining block.
package srcn_pkg;

    localparam int MAX_LEN_DEF  = 32768;
    localparam int ACC_BITS_DEF = 22;

    localparam int CL_W      = 16;
    localparam int SCALE_W   = 7;
    localparam int SOFT_W    = 16;
    localparam int NORM_W    = 8;
    localparam int Q_W       = NORM_W - 1;
    localparam int DIV_STEPS = Q_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [Q_W-1:0]     Q_MAX       = '1;
    localparam logic [CL_W-1:0]    CL_RESET    = 16'd1;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 7'd127;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_READ = 1'b1;

    localparam logic REG_CODE_LENGTH = 1'b0;
    localparam logic REG_OUT_SCALE   = 1'b1;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic ld_wr;
        logic scan_start;
        logic scan_rd;
        logic scan_done;
        logic mul;
        logic prep;
        logic div_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic mode;
        logic peak_valid;
        logic clr_last;
        logic scan_last;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: design/srcn_ctrl.sv
// Sequencer for clear sweep, load, peak scan, divide and output.
module srcn_ctrl
    import srcn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_stat_t   stat,
    output ctrl_cmd_t  cmd
);

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_EXEC     = 4'd2;
    localparam logic [3:0] ST_SCAN     = 4'd3;
    localparam logic [3:0] ST_SCAN_END = 4'd4;
    localparam logic [3:0] ST_MUL      = 4'd5;
    localparam logic [3:0] ST_PREP     = 4'd6;
    localparam logic [3:0] ST_DIV      = 4'd7;
    localparam logic [3:0] ST_OUT      = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] div_cnt_reg, div_cnt_next;

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.mode == MODE_LOAD)
                begin
                    cmd.ld_wr  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (stat.peak_valid)
                begin
                    cmd.mul    = 1'b1;
                    state_next = ST_PREP;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END:
            begin
                cmd.scan_done = 1'b1;
                state_next    = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep     = 1'b1;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

endmodule

FILE: design/srcn_dp.sv
// Datapath: combining store, positions, peak search, divider, output register.
module srcn_dp
    import srcn_pkg::*;
#(
    parameter int MAX_LEN  = MAX_LEN_DEF,
    parameter int ACC_BITS = ACC_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  ctrl_cmd_t                 cmd,
    output dp_stat_t                  stat,
    input  logic [CL_W-1:0]           code_length,
    input  logic [SCALE_W-1:0]        out_scale,
    input  logic                      mode,
    input  logic signed [SOFT_W-1:0]  soft_value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [NORM_W-1:0]  norm_value,
    output logic                      last
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int SW = ACC_BITS + 1;
    localparam int PW = ACC_BITS + SCALE_W;
    localparam int NW = ACC_BITS + SCALE_W + 2;
    localparam int DW = ACC_BITS + Q_W;

    logic [ACC_BITS-1:0] mem [MAX_LEN];
    logic [ACC_BITS-1:0] rd_data_reg;
    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_wa, mem_ra;
    logic [ACC_BITS-1:0] mem_wd;

    logic [AW-1:0]       wp_reg, wp_next;
    logic [AW-1:0]       rp_reg, rp_next;
    logic [AW-1:0]       sweep_reg, sweep_next;
    logic [ACC_BITS-1:0] peak_reg, peak_next;
    logic                peak_valid_reg, peak_valid_next;
    logic                scan_vld_reg;
    logic                out_valid_reg, out_valid_next;

    logic                      mode_reg;
    logic signed [SOFT_W-1:0]  soft_reg;
    logic [PW-1:0]             prod_reg;
    logic                      neg_reg;
    logic                      last_pend_reg;
    logic [NW-1:0]             rem_reg;
    logic [DW-1:0]             dsh_reg;
    logic [Q_W-1:0]            q_reg;
    logic                      sat_reg;
    logic                      zero_reg;
    logic signed [NORM_W-1:0]  norm_reg;
    logic                      out_last_reg;

    logic [LW-1:0]             len;
    logic [AW-1:0]             len_m1;
    logic [AW-1:0]             wp_wrap, rp_wrap;
    logic [ACC_BITS-1:0]       mag_w;
    logic signed [SW-1:0]      sum_w;
    logic [ACC_BITS-1:0]       sat_sum;
    logic [NW-1:0]             num_w;
    logic                      over_w;
    logic                      rem_ge;
    logic [Q_W-1:0]            qv;
    logic [NORM_W-1:0]         out_mag;
    logic signed [NORM_W-1:0]  norm_w;

    always_comb
    begin
        if (code_length == '0)
        begin
            len = LW'(1);
        end
        else if (32'(code_length) > 32'(MAX_LEN))
        begin
            len = LW'(MAX_LEN);
        end
        else
        begin
            len = LW'(code_length);
        end
    end

    assign len_m1  = AW'(len - LW'(1));
    assign wp_wrap = (LW'(wp_reg) >= len) ? '0 : wp_reg;
    assign rp_wrap = (LW'(rp_reg) >= len) ? '0 : rp_reg;

    assign mag_w = rd_data_reg[ACC_BITS-1] ? ACC_BITS'(~rd_data_reg + 1'b1) : rd_data_reg;
    assign sum_w = SW'($signed(rd_data_reg)) + SW'(soft_reg);

    always_comb
    begin
        if (sum_w[SW-1] != sum_w[SW-2])
        begin
            sat_sum = sum_w[SW-1] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                  : {1'b0, {(ACC_BITS-1){1'b1}}};
        end
        else
        begin
            sat_sum = sum_w[ACC_BITS-1:0];
        end
    end

    // round half away: (2*num + peak) / (2*peak); quotient >= 128 saturates
    assign num_w  = NW'({prod_reg, 1'b0}) + NW'(peak_reg);
    assign over_w = num_w[NW-1:Q_W+1] >= SW'(peak_reg);
    assign rem_ge = rem_reg >= NW'(dsh_reg);

    assign qv      = sat_reg ? Q_MAX : q_reg;
    assign out_mag = {1'b0, qv};
    assign norm_w  = zero_reg ? '0 : (neg_reg ? -$signed(out_mag) : $signed(out_mag));

    // store ports
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = sweep_reg;
        mem_wd = '0;
        if (cmd.clr_step)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.ld_wr)
        begin
            mem_we = 1'b1;
            mem_wa = wp_wrap;
            mem_wd = sat_sum;
        end
        else if (cmd.mul)
        begin
            mem_we = 1'b1;
            mem_wa = rp_wrap;
        end
        mem_re = cmd.accept | cmd.scan_rd | cmd.scan_done;
        if (cmd.scan_rd)
        begin
            mem_ra = sweep_reg;
        end
        else if (cmd.scan_done)
        begin
            mem_ra = '0;
        end
        else if (mode == MODE_LOAD)
        begin
            mem_ra = wp_wrap;
        end
        else
        begin
            mem_ra = rp_wrap;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    // positions, peak and flags
    always_comb
    begin
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        sweep_next      = sweep_reg;
        peak_next       = peak_reg;
        peak_valid_next = peak_valid_reg;
        if (cmd.clr_step || cmd.scan_rd)
        begin
            sweep_next = AW'(sweep_reg + 1'b1);
        end
        if (cmd.scan_start)
        begin
            sweep_next = '0;
            peak_next  = '0;
        end
        if (scan_vld_reg && (mag_w > peak_reg))
        begin
            peak_next = mag_w;
        end
        if (cmd.ld_wr)
        begin
            wp_next         = (wp_wrap == len_m1) ? '0 : AW'(wp_wrap + 1'b1);
            rp_next         = '0;
            peak_valid_next = 1'b0;
        end
        if (cmd.scan_done)
        begin
            rp_next         = '0;
            peak_valid_next = 1'b1;
        end
        if (cmd.mul)
        begin
            if (rp_wrap == len_m1)
            begin
                rp_next         = '0;
                wp_next         = '0;
                peak_valid_next = 1'b0;
            end
            else
            begin
                rp_next = AW'(rp_wrap + 1'b1);
            end
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg         <= '0;
            rp_reg         <= '0;
            sweep_reg      <= '0;
            peak_reg       <= '0;
            peak_valid_reg <= 1'b0;
            scan_vld_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            wp_reg         <= wp_next;
            rp_reg         <= rp_next;
            sweep_reg      <= sweep_next;
            peak_reg       <= peak_next;
            peak_valid_reg <= peak_valid_next;
            scan_vld_reg   <= cmd.scan_rd;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg <= mode;
            soft_reg <= soft_value;
        end
        if (cmd.mul)
        begin
            prod_reg      <= PW'(mag_w) * PW'(out_scale);
            neg_reg       <= rd_data_reg[ACC_BITS-1];
            last_pend_reg <= (rp_wrap == len_m1);
        end
        if (cmd.prep)
        begin
            rem_reg  <= num_w;
            dsh_reg  <= {peak_reg, {Q_W{1'b0}}};
            q_reg    <= '0;
            sat_reg  <= over_w;
            zero_reg <= (peak_reg == '0);
        end
        if (cmd.div_step)
        begin
            if (rem_ge)
            begin
                rem_reg <= rem_reg - NW'(dsh_reg);
            end
            q_reg   <= {q_reg[Q_W-2:0], rem_ge};
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.out_load)
        begin
            norm_reg     <= norm_w;
            out_last_reg <= last_pend_reg;
        end
    end

    assign stat.mode       = mode_reg;
    assign stat.peak_valid = peak_valid_reg;
    assign stat.clr_last   = (sweep_reg == AW'(MAX_LEN - 1));
    assign stat.scan_last  = (sweep_reg == len_m1);
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign norm_value = norm_reg;
    assign last       = out_last_reg;

endmodule

FILE: design/soft_repetition_combine_normalize.sv
// Top level: soft repetition combining with peak normalization.
//
//  channel  direction  handshake            payload
//  in       input      in_valid/in_ready    mode, soft_value
//  out      output     out_valid/out_ready  norm_value, last
//  cfg      input      APB psel/penable     code_length (0x0), out_scale (0x4)
//
// A load word reads its store entry, then adds with saturation and writes it back.
// A read request runs multiply, rounding prep, 7 divide steps, then output.
// The first read request after loading adds a peak scan over the code length,
// one store entry a cycle through the single read port.
// After reset a clearing pass over all MAX_LEN entries zeroes the store; in_ready is low.
// A finished result waits in the output register; a new word is taken meanwhile.
module soft_repetition_combine_normalize
    import srcn_pkg::*;
#(
    parameter int MAX_LEN  = MAX_LEN_DEF,
    parameter int ACC_BITS = ACC_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      mode,
    input  logic signed [SOFT_W-1:0]  soft_value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [NORM_W-1:0]  norm_value,
    output logic                      last,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready
);

`include "soft_repetition_combine_normalize_defines.svh"

    logic [CL_W-1:0]    code_length_reg;
    logic [SCALE_W-1:0] out_scale_reg;
    logic               cfg_wr;
    ctrl_cmd_t          cmd;
    dp_stat_t           stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_length_reg <= CL_RESET;
            out_scale_reg   <= SCALE_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_CODE_LENGTH: code_length_reg <= pwdata[CL_W-1:0];
                REG_OUT_SCALE:   out_scale_reg   <= pwdata[SCALE_W-1:0];
                default:         code_length_reg <= code_length_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_CODE_LENGTH: prdata = PDATA_W'(code_length_reg);
            REG_OUT_SCALE:   prdata = PDATA_W'(out_scale_reg);
            default:         prdata = '0;
        endcase
    end

    srcn_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    srcn_dp
    #(
        .MAX_LEN  (MAX_LEN),
        .ACC_BITS (ACC_BITS)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .code_length (code_length_reg),
        .out_scale   (out_scale_reg),
        .mode        (mode),
        .soft_value  (soft_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .norm_value  (norm_value),
        .last        (last)
    );

    `SRCN_ASSERT_IMP(a_one_writer, clk, rst_n, cmd.clr_step || cmd.ld_wr || cmd.mul, $onehot0({cmd.clr_step, cmd.ld_wr, cmd.mul}), "store written from two sources")
    `SRCN_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready, "word taken while one is in flight")
    `SRCN_ASSERT_IMP(a_out_free, clk, rst_n, cmd.out_load, stat.out_free, "result overwrites a pending word")

endmodule

FILE: verif/tb_top.sv
// Testbench for soft_repetition_combine_normalize: directed table, then random bursts vs predictor.
`timescale 1ns / 100ps

module tb_top;
    import srcn_pkg::*;

    localparam int     SETTLE_CYCLES  = 40;
    localparam int     WATCHDOG_LIMIT = 200000;
    localparam int     RAND_WORDS     = 1400;
    localparam int     HOLD_CYCLES    = 400;
    localparam longint ACC_MAX        = (longint'(1) <<< (ACC_BITS_DEF - 1)) - 1;
    localparam longint ACC_MIN        = -ACC_MAX - 1;

    typedef struct packed {
        logic signed [NORM_W-1:0] norm;
        logic                     last;
    } norm_word_t;

    typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

    typedef struct packed {
        row_kind_t                kind;
        logic                     reg_sel;
        logic [CL_W-1:0]          cfg_val;
        logic                     word_mode;
        logic signed [SOFT_W-1:0] word_soft;
        logic                     typed;
        norm_word_t               typed_res;
    } dir_row_t;

    function automatic dir_row_t cfg_row(input logic sel, input logic [CL_W-1:0] val);
        dir_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.reg_sel = sel;
        r.cfg_val = val;
        return r;
    endfunction

    function automatic dir_row_t word_row(input logic m, input logic signed [SOFT_W-1:0] v);
        dir_row_t r;
        r = '0;
        r.kind = ROW_WORD;
        r.word_mode = m;
        r.word_soft = v;
        return r;
    endfunction

    function automatic dir_row_t typed_read(input logic signed [NORM_W-1:0] n, input logic l);
        dir_row_t r;
        r = word_row(MODE_READ, '0);
        r.typed = 1'b1;
        r.typed_res.norm = n;
        r.typed_res.last = l;
        return r;
    endfunction

    localparam int DIR_N = 33;
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        // reset settings: length 1, scale 127; zero peak first
        typed_read(8'sd0, 1'b1),
        word_row(MODE_LOAD, 16'sh7FFF),
        word_row(MODE_LOAD, 16'sh8000),
        typed_read(-8'sd127, 1'b1),
        word_row(MODE_LOAD, 16'sh7FFF),
        typed_read(8'sd127, 1'b1),
        word_row(MODE_LOAD, 16'sd0),
        typed_read(8'sd0, 1'b1),
        // length 0 behaves as 1; scale 0 gives 0
        cfg_row(REG_CODE_LENGTH, 16'd0),
        cfg_row(REG_OUT_SCALE, 16'd0),
        word_row(MODE_LOAD, 16'sd1000),
        typed_read(8'sd0, 1'b1),
        // load in the middle of a readout restarts it
        cfg_row(REG_CODE_LENGTH, 16'd3),
        cfg_row(REG_OUT_SCALE, 16'd100),
        word_row(MODE_LOAD, 16'sd300),
        word_row(MODE_LOAD, -16'sd150),
        word_row(MODE_LOAD, 16'sd75),
        word_row(MODE_READ, 16'sh7FFF),
        word_row(MODE_LOAD, 16'sd5),
        word_row(MODE_READ, 16'sh8000),
        word_row(MODE_READ, 16'sd0),
        word_row(MODE_READ, -16'sd1),
        // shrink length below the write position
        cfg_row(REG_CODE_LENGTH, 16'd4),
        cfg_row(REG_OUT_SCALE, 16'd127),
        word_row(MODE_LOAD, 16'sd10),
        word_row(MODE_LOAD, -16'sd20),
        word_row(MODE_LOAD, 16'sd30),
        cfg_row(REG_CODE_LENGTH, 16'd2),
        word_row(MODE_LOAD, 16'sd40),
        word_row(MODE_READ, 16'sd0),
        word_row(MODE_READ, 16'sd0),
        // oversized length clamps to the full store
        cfg_row(REG_CODE_LENGTH, 16'hFFFF),
        word_row(MODE_READ, 16'sd0)
    };

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     in_valid   = 1'b0;
    logic                     in_ready;
    logic                     mode       = MODE_LOAD;
    logic signed [SOFT_W-1:0] soft_value = '0;
    logic                     out_valid;
    logic                     out_ready  = 1'b0;
    logic signed [NORM_W-1:0] norm_value;
    logic                     last;
    logic                     psel       = 1'b0;
    logic                     penable    = 1'b0;
    logic                     pwrite     = 1'b0;
    logic [PADDR_W-1:0]       paddr      = '0;
    logic [PDATA_W-1:0]       pwdata     = '0;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;

    // predictor state
    logic signed [ACC_BITS_DEF-1:0] llr_sum [MAX_LEN_DEF];
    int unsigned                    wr_pos;
    int unsigned                    rd_pos;
    longint                         peak;
    bit                             peak_ok;
    logic [CL_W-1:0]                cl_reg;
    logic [SCALE_W-1:0]             scale_reg;

    norm_word_t  pending_norm_q [$];
    int          errors       = 0;
    int unsigned words_sent   = 0;
    int unsigned burst_left   = 0;
    int unsigned quiet_cycles = 0;
    bit          hold_req     = 1'b0;

    soft_repetition_combine_normalize i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .soft_value (soft_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .norm_value (norm_value),
        .last       (last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Returns 1 with the normalized word when the input word is a read request.
    function automatic bit predict_normalized(input logic m, input logic signed [SOFT_W-1:0] v,
                                              output norm_word_t res);
        int unsigned len;
        int unsigned i;
        longint      s;
        longint      mag;
        longint      q;
        len = (cl_reg == 0) ? 1 : ((cl_reg > MAX_LEN_DEF) ? MAX_LEN_DEF : int'(cl_reg));
        res = '0;
        if (m == MODE_LOAD)
        begin
            if (wr_pos >= len)
                wr_pos = 0;
            s = longint'(llr_sum[wr_pos]) + longint'(v);
            if (s > ACC_MAX)
                s = ACC_MAX;
            if (s < ACC_MIN)
                s = ACC_MIN;
            llr_sum[wr_pos] = s[ACC_BITS_DEF-1:0];
            wr_pos = (wr_pos + 1 >= len) ? 0 : wr_pos + 1;
            peak_ok = 1'b0;
            rd_pos = 0;
            return 1'b0;
        end
        if (!peak_ok)
        begin
            peak = 0;
            for (i = 0; i < len; i++)
            begin
                mag = longint'(llr_sum[i]);
                if (mag < 0)
                    mag = -mag;
                if (mag > peak)
                    peak = mag;
            end
            peak_ok = 1'b1;
            rd_pos = 0;
        end
        if (rd_pos >= len)
            rd_pos = 0;
        s = longint'(llr_sum[rd_pos]);
        if (peak != 0)
        begin
            mag = (s < 0) ? -s : s;
            q = (2 * mag * longint'(scale_reg) + peak) / (2 * peak);
            if (q > longint'(Q_MAX))
                q = longint'(Q_MAX);
            if (s < 0)
                q = -q;
            res.norm = q[NORM_W-1:0];
        end
        res.last = (rd_pos == len - 1);
        llr_sum[rd_pos] = '0;
        if (res.last)
        begin
            rd_pos = 0;
            wr_pos = 0;
            peak_ok = 1'b0;
        end
        else
            rd_pos++;
        return 1'b1;
    endfunction

    function automatic logic signed [SOFT_W-1:0] pick_soft();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3:    return SOFT_W'($urandom_range(0, 16)) - 16'sd8;
            default: return SOFT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_word(input logic m, input logic signed [SOFT_W-1:0] v,
                             input logic use_typed = 1'b0, input norm_word_t typed_res = '0);
        int unsigned gap;
        norm_word_t  res;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 9) == 0)
                burst_left = $urandom_range(80, 200);
            else
                burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        mode       <= m;
        soft_value <= v;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
        if (predict_normalized(m, v, res))
        begin
            if (use_typed)
                res = typed_res;
            pending_norm_q.push_back(res);
        end
    endtask

    // Wait for every expected word, then let in-flight loads finish.
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (pending_norm_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic sel, input logic [CL_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= PDATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (sel == REG_CODE_LENGTH)
            cl_reg = val;
        else
            scale_reg = val[SCALE_W-1:0];
    endtask

    initial
    begin : receiver
        int unsigned hold_left;
        int unsigned pat_cyc;
        int unsigned stall_mode;
        norm_word_t  want;
        hold_left  = 0;
        pat_cyc    = 0;
        stall_mode = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pending_norm_q.size() == 0)
                begin
                    $display("%0t: unexpected word norm_value %0d last %0b",
                             $time, norm_value, last);
                    errors++;
                end
                else
                begin
                    want = pending_norm_q.pop_front();
                    if (norm_value !== want.norm)
                    begin
                        $display("%0t: norm_value expected %0d, got %0d",
                                 $time, want.norm, norm_value);
                        errors++;
                    end
                    if (last !== want.last)
                    begin
                        $display("%0t: last expected %0b, got %0b", $time, want.last, last);
                        errors++;
                    end
                end
            end
            pat_cyc++;
            if (pat_cyc % 300 == 0)
                stall_mode = $urandom_range(0, 3);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 9) != 0);
                    default: out_ready <= (pat_cyc % 4 == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("FAIL soft_repetition_combine_normalize");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        int unsigned       r;
        int unsigned       phase_no;
        int unsigned       large_left;
        int unsigned       phase_end;
        int unsigned       len_now;
        int unsigned       reps;
        int unsigned       k;
        bit                neg;
        logic [CL_W-1:0]   cl_pick;
        logic [CL_W-1:0]   scale_pick;
        logic signed [SOFT_W-1:0] v;

        foreach (llr_sum[i])
            llr_sum[i] = '0;
        wr_pos     = 0;
        rd_pos     = 0;
        peak       = 0;
        peak_ok    = 1'b0;
        cl_reg     = CL_RESET;
        scale_reg  = SCALE_RESET;
        phase_no   = 0;
        large_left = 2;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < DIR_N; r++)
        begin
            if (DIR_ROWS[r].kind == ROW_CFG)
            begin
                settle_idle();
                write_reg(DIR_ROWS[r].reg_sel, DIR_ROWS[r].cfg_val);
            end
            else
                send_word(DIR_ROWS[r].word_mode, DIR_ROWS[r].word_soft,
                          DIR_ROWS[r].typed, DIR_ROWS[r].typed_res);
        end

        while (words_sent < DIR_N + RAND_WORDS)
        begin
            settle_idle();
            phase_no++;
            case ($urandom_range(0, 9))
                0:       scale_pick = 16'd0;
                1:       scale_pick = 16'd1;
                2:       scale_pick = 16'd127;
                default: scale_pick = CL_W'($urandom_range(0, 127));
            endcase
            if (phase_no == 3 || (large_left != 0 && $urandom_range(0, 9) == 0))
            begin
                if (large_left != 0)
                    large_left--;
                cl_pick = ($urandom_range(0, 1) != 0) ? 16'hFFFF : CL_W'(MAX_LEN_DEF);
                write_reg(REG_CODE_LENGTH, cl_pick);
                write_reg(REG_OUT_SCALE, scale_pick);
                // full-size store: two scans only
                repeat ($urandom_range(1, 6)) send_word(MODE_LOAD, pick_soft());
                repeat (3) send_word(MODE_READ, pick_soft());
                repeat (2) send_word(MODE_LOAD, pick_soft());
                repeat (2) send_word(MODE_READ, pick_soft());
                continue;
            end
            case ($urandom_range(0, 9))
                0:       cl_pick = 16'd0;
                1:       cl_pick = 16'd1;
                2, 3:    cl_pick = CL_W'($urandom_range(17, 120));
                default: cl_pick = CL_W'($urandom_range(2, 16));
            endcase
            if (phase_no == 1)
            begin
                cl_pick  = 16'd8;
                hold_req = 1'b1;
            end
            write_reg(REG_CODE_LENGTH, cl_pick);
            write_reg(REG_OUT_SCALE, scale_pick);
            len_now   = (cl_pick == 0) ? 1 : cl_pick;
            phase_end = words_sent + $urandom_range(60, 160);
            while (words_sent < phase_end)
            begin
                if ($urandom_range(0, 9) < 3)
                begin
                    repeat ($urandom_range(1, 12))
                        send_word(($urandom_range(0, 1) != 0) ? MODE_READ : MODE_LOAD,
                                  pick_soft());
                end
                else
                begin
                    // repeated passes over the code length, then a full readout
                    if (len_now <= 2 && $urandom_range(0, 3) == 0)
                        reps = $urandom_range(40, 70);
                    else
                        reps = $urandom_range(1, 3);
                    neg = 1'($urandom_range(0, 1));
                    for (k = 0; k < reps * len_now; k++)
                    begin
                        if (reps >= 40 && $urandom_range(0, 4) != 0)
                            v = neg ? 16'sh8000 : 16'sh7FFF;
                        else
                            v = pick_soft();
                        send_word(MODE_LOAD, v);
                    end
                    repeat (len_now) send_word(MODE_READ, pick_soft());
                end
            end
        end

        settle_idle();
        if (errors == 0)
            $display("PASS soft_repetition_combine_normalize");
        else
            $display("FAIL soft_repetition_combine_normalize");
        $finish;
    end

endmodule
